// File: hdl/tkps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkps_pkg: shared definitions for the top-K pair sums block
// Default sizes, request function codes and the cell control group.
// ----------------------------------------------------------------------------
package tkps_pkg;

	localparam int DEF_MAX_LEN    = 64;
	localparam int DEF_MAX_K      = 64;
	localparam int DEF_VALUE_BITS = 16;

	// The wanted count port is fixed by the request format.
	localparam int KPORT_W = 7;

	localparam logic [1:0] FUNC_LOAD_A = 2'd0;
	localparam logic [1:0] FUNC_LOAD_B = 2'd1;
	localparam logic [1:0] FUNC_RUN    = 2'd2;

	typedef struct packed {
		logic clr;
		logic pop;
		logic ins;
	} cell_ctl_t;

endpackage

// File: hdl/tkps_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkps_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tkps_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/tkps_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkps_cell: one cell of a sorted insertion chain
// Holds one key; on insert the chain opens a slot at the right place, on pop
// every cell takes its lower neighbor's key.
// ----------------------------------------------------------------------------
module tkps_cell
	import tkps_pkg::*;
#(
	parameter int  KEY_W  = 16,
	parameter bit  ASCEND = 1'b1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctl_t        ctl,
	input  logic [KEY_W-1:0] x_key,
	input  logic             prev_v,
	input  logic [KEY_W-1:0] prev_key,
	input  logic             prev_outranks,
	input  logic             next_v,
	input  logic [KEY_W-1:0] next_key,
	output logic             v,
	output logic [KEY_W-1:0] key,
	output logic             outranks,
	output logic             match
);

	logic             v_q;
	logic [KEY_W-1:0] key_q;
	logic             v_d;
	logic [KEY_W-1:0] key_d;

	always_comb begin
		if (ASCEND) begin
			outranks = v_q && (key_q <= x_key);
		end else begin
			outranks = v_q && (key_q > x_key);
		end
		match = v_q && (key_q == x_key);
	end

	always_comb begin
		v_d   = v_q;
		key_d = key_q;
		priority if (ctl.clr) begin
			v_d = 1'b0;
		end else if (ctl.pop) begin
			v_d   = next_v;
			key_d = next_key;
		end else if (ctl.ins) begin
			// The new key lands above this cell, so this cell takes the one above.
			if (!prev_outranks) begin
				v_d   = prev_v;
				key_d = prev_key;
			end else if (!outranks) begin
				v_d   = 1'b1;
				key_d = x_key;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
	end

	assign v   = v_q;
	assign key = key_q;

endmodule

// File: hdl/top_k_pair_sums.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_pair_sums: the K largest sums of pairs drawn from two arrays
// Load requests insert into two sorted cell chains; a run request emits the
// largest pair sums in descending order from a sorted candidate chain.
// ----------------------------------------------------------------------------
// A load request inserts the value into its sorted chain of MAX_LEN cells
// at once. A run request first moves both sorted chains into two RAMs, one
// entry per cycle, then seeds the candidate chain in ST_SEED and ST_SEEDP,
// and then steps through ST_POP, ST_RD1, ST_RD2 and ST_EMIT for each sum:
// ST_POP pops the best candidate, in ST_RD1 and ST_RD2 the RAM reads for its
// two neighbor pairs return and the new candidates are inserted, and ST_EMIT
// emits the sum once the result is not held by res_stall. A run with K zero
// or an empty array gives one empty result. No request is taken while a run is in progress.
module top_k_pair_sums
	import tkps_pkg::*;
#(
	parameter int MAX_LEN    = DEF_MAX_LEN,
	parameter int MAX_K      = DEF_MAX_K,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [1:0]                   func,
	input  logic signed [VALUE_BITS-1:0] value,
	input  logic [KPORT_W-1:0]           want_count,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic signed [VALUE_BITS:0]   sum,
	output logic                         last,
	output logic                         empty_res
);

	localparam int VB  = VALUE_BITS;
	localparam int SW  = VALUE_BITS + 1;
	localparam int IW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CW  = $clog2(MAX_LEN + 1);
	localparam int KW  = $clog2(MAX_K + 1);
	localparam int CD  = MAX_K + 1;
	localparam int CKW = SW + 2 * IW;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_EMPTY = 4'd1;
	localparam logic [3:0] ST_COPY  = 4'd2;
	localparam logic [3:0] ST_SEED  = 4'd3;
	localparam logic [3:0] ST_SEEDP = 4'd4;
	localparam logic [3:0] ST_POP   = 4'd5;
	localparam logic [3:0] ST_RD1   = 4'd6;
	localparam logic [3:0] ST_RD2   = 4'd7;
	localparam logic [3:0] ST_EMIT  = 4'd8;

	logic [3:0]    state_q;
	logic [CW-1:0] cnt_a_q, cnt_b_q;
	logic [KW-1:0] k_q, n_q;
	logic [IW-1:0] ptr_q;
	logic [IW-1:0] pend_i_q, pend_j_q;
	logic [SW-1:0] pend_sum_q;
	logic          out_v_q, last_q, empty_q;
	logic [SW-1:0] sum_q;

	logic req_acc, out_free;
	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign out_free  = !out_v_q || !res_stall;

	// Sorted load chains (ascending, cell 0 smallest).
	logic [VB-1:0] ld_key;
	cell_ctl_t     sa_ctl, sb_ctl;
	logic          sa_v [MAX_LEN];
	logic [VB-1:0] sa_k [MAX_LEN];
	logic          sa_o [MAX_LEN];
	logic          sa_m [MAX_LEN];
	logic          sb_v [MAX_LEN];
	logic [VB-1:0] sb_k [MAX_LEN];
	logic          sb_o [MAX_LEN];
	logic          sb_m [MAX_LEN];

	assign ld_key = {~value[VB-1], value[VB-2:0]};

	logic load_a, load_b, copying, clr_sort;
	assign load_a   = req_acc && (func == FUNC_LOAD_A) && (cnt_a_q != CW'(MAX_LEN));
	assign load_b   = req_acc && (func == FUNC_LOAD_B) && (cnt_b_q != CW'(MAX_LEN));
	assign copying  = (state_q == ST_COPY);
	assign clr_sort = (state_q == ST_EMPTY) && out_free;

	always_comb begin
		sa_ctl     = '0;
		sb_ctl     = '0;
		sa_ctl.ins = load_a;
		sb_ctl.ins = load_b;
		sa_ctl.pop = copying;
		sb_ctl.pop = copying;
		sa_ctl.clr = clr_sort;
		sb_ctl.clr = clr_sort;
	end

	for (genvar c = 0; c < MAX_LEN; c++) begin : g_sort
		logic          pa_v, pa_o, na_v, pb_v, pb_o, nb_v;
		logic [VB-1:0] pa_k, na_k, pb_k, nb_k;
		if (c == 0) begin : g_head
			assign pa_v = 1'b0;
			assign pa_k = '0;
			assign pa_o = 1'b1;
			assign pb_v = 1'b0;
			assign pb_k = '0;
			assign pb_o = 1'b1;
		end else begin : g_body
			assign pa_v = sa_v[c-1];
			assign pa_k = sa_k[c-1];
			assign pa_o = sa_o[c-1];
			assign pb_v = sb_v[c-1];
			assign pb_k = sb_k[c-1];
			assign pb_o = sb_o[c-1];
		end
		if (c == MAX_LEN - 1) begin : g_tail
			assign na_v = 1'b0;
			assign na_k = '0;
			assign nb_v = 1'b0;
			assign nb_k = '0;
		end else begin : g_mid
			assign na_v = sa_v[c+1];
			assign na_k = sa_k[c+1];
			assign nb_v = sb_v[c+1];
			assign nb_k = sb_k[c+1];
		end
		tkps_cell #(.KEY_W(VB), .ASCEND(1'b1)) u_a (
			.clk(clk), .arst_n(arst_n), .ctl(sa_ctl), .x_key(ld_key),
			.prev_v(pa_v), .prev_key(pa_k), .prev_outranks(pa_o),
			.next_v(na_v), .next_key(na_k),
			.v(sa_v[c]), .key(sa_k[c]), .outranks(sa_o[c]), .match(sa_m[c])
		);
		tkps_cell #(.KEY_W(VB), .ASCEND(1'b1)) u_b (
			.clk(clk), .arst_n(arst_n), .ctl(sb_ctl), .x_key(ld_key),
			.prev_v(pb_v), .prev_key(pb_k), .prev_outranks(pb_o),
			.next_v(nb_v), .next_key(nb_k),
			.v(sb_v[c]), .key(sb_k[c]), .outranks(sb_o[c]), .match(sb_m[c])
		);
	end

	// Sorted arrays in RAM.
	logic [IW-1:0] ra_addr, rb_addr;
	logic [VB-1:0] ra_data, rb_data, wa_data, wb_data;
	assign wa_data = {~sa_k[0][VB-1], sa_k[0][VB-2:0]};
	assign wb_data = {~sb_k[0][VB-1], sb_k[0][VB-2:0]};

	tkps_ram #(.WIDTH(VB), .DEPTH(MAX_LEN)) u_ram_a (
		.clk(clk), .we(copying), .waddr(ptr_q), .wdata(wa_data),
		.raddr(ra_addr), .rdata(ra_data)
	);
	tkps_ram #(.WIDTH(VB), .DEPTH(MAX_LEN)) u_ram_b (
		.clk(clk), .we(copying), .waddr(ptr_q), .wdata(wb_data),
		.raddr(rb_addr), .rdata(rb_data)
	);

	// Candidate chain (descending, cell 0 best).
	cell_ctl_t      cc_ctl;
	logic [CKW-1:0] c_key;
	logic           cv [CD];
	logic [CKW-1:0] ck [CD];
	logic           co [CD];
	logic           cm [CD];
	logic           dup;
	logic [SW-1:0]  new_sum;
	logic [IW-1:0]  new_i, new_j;
	logic [CW-1:0]  cnt_a_m1, cnt_b_m1;
	logic [IW-1:0]  top_i, top_j;

	assign new_sum  = {ra_data[VB-1], ra_data} + {rb_data[VB-1], rb_data};
	assign c_key    = {~new_sum[SW-1], new_sum[SW-2:0], new_i, new_j};
	assign cnt_a_m1 = cnt_a_q - CW'(1);
	assign cnt_b_m1 = cnt_b_q - CW'(1);
	assign top_i    = ck[0][2*IW-1:IW];
	assign top_j    = ck[0][IW-1:0];

	always_comb begin
		dup = 1'b0;
		for (int c = 0; c < CD; c++) begin
			dup = dup | cm[c];
		end
	end

	for (genvar c = 0; c < CD; c++) begin : g_cand
		logic           p_v, p_o, n_v;
		logic [CKW-1:0] p_k, n_k;
		if (c == 0) begin : g_head
			assign p_v = 1'b0;
			assign p_k = '0;
			assign p_o = 1'b1;
		end else begin : g_body
			assign p_v = cv[c-1];
			assign p_k = ck[c-1];
			assign p_o = co[c-1];
		end
		if (c == CD - 1) begin : g_tail
			assign n_v = 1'b0;
			assign n_k = '0;
		end else begin : g_mid
			assign n_v = cv[c+1];
			assign n_k = ck[c+1];
		end
		tkps_cell #(.KEY_W(CKW), .ASCEND(1'b0)) u_c (
			.clk(clk), .arst_n(arst_n), .ctl(cc_ctl), .x_key(c_key),
			.prev_v(p_v), .prev_key(p_k), .prev_outranks(p_o),
			.next_v(n_v), .next_key(n_k),
			.v(cv[c]), .key(ck[c]), .outranks(co[c]), .match(cm[c])
		);
	end

	logic          emit_go, emit_last;
	logic [KW-1:0] n_inc;
	assign n_inc     = n_q + KW'(1);
	assign emit_go   = (state_q == ST_EMIT) && out_free;
	assign emit_last = (n_inc == k_q) || !cv[0];

	always_comb begin
		ra_addr    = pend_i_q;
		rb_addr    = pend_j_q;
		new_i      = pend_i_q;
		new_j      = pend_j_q;
		cc_ctl     = '0;
		cc_ctl.clr = req_acc && (func == FUNC_RUN);
		unique case (state_q)
			ST_SEED: begin
				ra_addr = cnt_a_m1[IW-1:0];
				rb_addr = cnt_b_m1[IW-1:0];
			end
			ST_SEEDP: begin
				cc_ctl.ins = 1'b1;
			end
			ST_POP: begin
				ra_addr    = top_i - IW'(1);
				rb_addr    = top_j;
				cc_ctl.pop = 1'b1;
			end
			ST_RD1: begin
				new_i      = pend_i_q - IW'(1);
				rb_addr    = pend_j_q - IW'(1);
				cc_ctl.ins = (pend_i_q != '0) && !dup;
			end
			ST_RD2: begin
				new_j      = pend_j_q - IW'(1);
				cc_ctl.ins = (pend_j_q != '0) && !dup;
			end
			default: begin
			end
		endcase
	end

	logic [KW-1:0] k_sat;
	assign k_sat = (want_count > KPORT_W'(MAX_K)) ? KW'(MAX_K) : want_count[KW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (out_v_q && !res_stall) begin
				out_v_q <= 1'b0;
			end
			if (load_a) begin
				cnt_a_q <= cnt_a_q + CW'(1);
			end
			if (load_b) begin
				cnt_b_q <= cnt_b_q + CW'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc && (func == FUNC_RUN)) begin
						if ((want_count == '0) || (cnt_a_q == '0) || (cnt_b_q == '0)) begin
							state_q <= ST_EMPTY;
						end else begin
							state_q <= ST_COPY;
						end
					end
				end
				ST_EMPTY: begin
					if (out_free) begin
						out_v_q <= 1'b1;
						cnt_a_q <= '0;
						cnt_b_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_COPY: begin
					if (ptr_q == IW'(MAX_LEN - 1)) begin
						state_q <= ST_SEED;
					end
				end
				ST_SEED:  state_q <= ST_SEEDP;
				ST_SEEDP: state_q <= ST_POP;
				ST_POP:   state_q <= ST_RD1;
				ST_RD1:   state_q <= ST_RD2;
				ST_RD2:   state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_free) begin
						out_v_q <= 1'b1;
						if (emit_last) begin
							cnt_a_q <= '0;
							cnt_b_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_POP;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc && (func == FUNC_RUN)) begin
			k_q   <= k_sat;
			n_q   <= '0;
			ptr_q <= '0;
		end
		if (copying) begin
			ptr_q <= ptr_q + IW'(1);
		end
		if (state_q == ST_SEED) begin
			pend_i_q <= cnt_a_m1[IW-1:0];
			pend_j_q <= cnt_b_m1[IW-1:0];
		end
		if (state_q == ST_POP) begin
			pend_i_q   <= top_i;
			pend_j_q   <= top_j;
			pend_sum_q <= {~ck[0][CKW-1], ck[0][CKW-2:2*IW]};
		end
		if (state_q == ST_EMPTY && out_free) begin
			sum_q   <= '0;
			last_q  <= 1'b1;
			empty_q <= 1'b1;
		end
		if (emit_go) begin
			sum_q   <= pend_sum_q;
			last_q  <= emit_last;
			empty_q <= 1'b0;
			n_q     <= n_inc;
		end
	end

	assign res_valid = out_v_q;
	assign sum       = sum_q;
	assign last      = last_q;
	assign empty_res = empty_q;

endmodule
